// ----- rtl/ctd_pkg.sv -----
`timescale 1ns / 1ps

package ctd_pkg;

	// Sizing of the calibration buffer
	localparam int CAL_SAMPLES_DEF    = 10;
	localparam int TRIM_EACH_SIDE_DEF = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TOUCH_MARGIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_MULTIPLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_COUNT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_SINGLE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_CONTINUOUS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_LIMIT      = 3'd5;

	// Register reset values
	localparam logic [15:0] TOUCH_MARGIN_RST     = 16'd100;
	localparam logic [3:0]  UPPER_MULTIPLE_RST   = 4'd10;
	localparam logic [3:0]  HOLDOFF_COUNT_RST    = 4'd3;
	localparam logic [3:0]  GROUP_SINGLE_RST     = 4'd3;
	localparam logic [3:0]  GROUP_CONTINUOUS_RST = 4'd6;
	localparam logic [15:0] FAULT_LIMIT_RST      = 16'd32767;

	// Command and result kinds
	localparam logic CMD_CAL  = 1'b0;
	localparam logic CMD_SCAN = 1'b1;
	localparam logic KIND_CAL  = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] sample;
		logic        continuous;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic        touched;
		logic [15:0] peak;
		logic [15:0] baseline;
		logic        fault;
	} out_item_t;

endpackage

// ----- rtl/capacitive_touch_detector_top.sv -----
// Scan beat that closes a group: update (S_SCAN), evaluate (S_EVAL) and hand-over (S_PUSH),
// then ready again; a scan beat that leaves its group open goes back to idle after evaluate,
// and a calibration beat that does not fill the buffer leaves the block ready. The filling
// calibration beat runs rank counting, the reciprocal multiply (S_DIV) and hand-over.
// Hand-over waits while the previous result beat is stalled at the output.
// Reset (arst_n low) clears control, counters, baseline, lockout and registers; not the buffer.
`timescale 1ns / 1ps

module capacitive_touch_detector_top #(
	parameter int CAL_SAMPLES    = ctd_pkg::CAL_SAMPLES_DEF,
	parameter int TRIM_EACH_SIDE = ctd_pkg::TRIM_EACH_SIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ctd_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ctd_pkg::out_item_t             out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Derived sizes
	localparam int TRIM   = (2 * TRIM_EACH_SIDE >= CAL_SAMPLES) ?
				(CAL_SAMPLES - 1) / 2 : TRIM_EACH_SIDE;
	localparam int KEPT   = CAL_SAMPLES - 2 * TRIM;
	localparam int IDX_W  = $clog2(CAL_SAMPLES);
	localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
	localparam int SUM_W  = 16 + $clog2(CAL_SAMPLES);

	// Reciprocal of the kept count, exact for any sum below 2**SUM_W
	localparam int               DIV_SH = SUM_W + $clog2(KEPT);
	localparam int               RCP_W  = SUM_W + 1;
	localparam int               PROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP  =
				RCP_W'(((64'd1 << DIV_SH) + 64'(KEPT) - 64'd1) / 64'(KEPT));

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_CAL_PIVOT = 9'b000000010,
		S_CAL_LATCH = 9'b000000100,
		S_CAL_RANK  = 9'b000001000,
		S_CAL_ACC   = 9'b000010000,
		S_DIV       = 9'b000100000,
		S_SCAN      = 9'b001000000,
		S_EVAL      = 9'b010000000,
		S_PUSH      = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [15:0] touch_margin_q;
	logic [3:0]  upper_multiple_q;
	logic [3:0]  holdoff_count_q;
	logic [3:0]  group_single_q;
	logic [3:0]  group_continuous_q;
	logic [15:0] fault_limit_q;

	// Detector state
	logic [IDX_W-1:0] cal_cnt_q;
	logic [15:0]      baseline_q;
	logic [3:0]       lockout_q;
	logic [3:0]       group_count_q;
	logic [15:0]      group_peak_q;
	logic             group_mode_q;

	// Sequencer working registers
	logic [IDX_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  rank_q;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              cmp_vld_s1;
	logic [15:0]       pivot_q;
	logic [SUM_W-1:0]  sum_q;
	logic [15:0]       smp_q;
	logic              cont_q;

	// Result staging
	ctd_pkg::out_item_t res_q;
	ctd_pkg::out_item_t res_d;
	logic               res_load;

	// Sample buffer
	logic [15:0]      cal_mem [CAL_SAMPLES];
	logic [IDX_W-1:0] rd_addr;
	logic [15:0]      rd_data_q;
	logic             mem_we;

	logic in_acc;
	logic out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;
	assign mem_we    = in_acc && (in_item.cmd == ctd_pkg::CMD_CAL);

	// Buffer write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cal_mem[cal_cnt_q] <= in_item.sample;
		end
		rd_data_q <= cal_mem[rd_addr];
	end

	always_comb begin
		if (state_q == S_CAL_PIVOT) begin
			rd_addr = i_q;
		end else if (j_q == CNT_W'(CAL_SAMPLES)) begin
			rd_addr = '0;
		end else begin
			rd_addr = j_q[IDX_W-1:0];
		end
	end

	// Rank compare: ties broken by buffer position
	logic cmp_less;
	assign cmp_less = (rd_data_q < pivot_q) ||
			((rd_data_q == pivot_q) && (cmp_idx_s1 < i_q));

	logic             rank_in;
	logic [SUM_W-1:0] sum_nxt;
	assign rank_in = (rank_q >= CNT_W'(TRIM)) && (rank_q < CNT_W'(TRIM + KEPT));
	assign sum_nxt = rank_in ? sum_q + SUM_W'(pivot_q) : sum_q;

	// Mean of the kept values: multiply by the reciprocal and drop the fraction
	logic [PROD_W-1:0] prod;
	logic [15:0]       quot;
	assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);
	assign quot = prod[DIV_SH +: 16];

	// Scan group update
	logic [15:0] peak_base;
	logic [15:0] peak_new;
	logic        mode_new;
	assign mode_new  = (group_count_q == 4'd0) ? cont_q : group_mode_q;
	assign peak_base = (group_count_q == 4'd0) ? 16'd0 : group_peak_q;
	assign peak_new  = (smp_q > peak_base) ? smp_q : peak_base;

	// Scan group evaluation
	logic [3:0]  size_raw;
	logic [3:0]  size;
	logic        grp_open;
	logic [16:0] lower_lim;
	logic [19:0] upper_lim;
	logic        hit;
	logic        touched;
	logic [3:0]  lock_ld;
	logic [3:0]  lock_nxt;
	assign size_raw  = group_mode_q ? group_continuous_q : group_single_q;
	assign size      = (size_raw == 4'd0) ? 4'd1 : size_raw;
	assign grp_open  = (group_count_q != 4'd0) && (group_count_q < size);
	assign lower_lim = {1'b0, baseline_q} + {1'b0, touch_margin_q};
	assign upper_lim = {4'd0, baseline_q} * {16'd0, upper_multiple_q};
	assign hit       = ({1'b0, group_peak_q} > lower_lim) &&
			({4'd0, group_peak_q} < upper_lim);
	assign touched   = hit && (lockout_q == 4'd0);
	assign lock_ld   = hit ? holdoff_count_q : lockout_q;
	assign lock_nxt  = (lock_ld != 4'd0) ? lock_ld - 4'd1 : lock_ld;

	// Result word for whichever path finishes
	always_comb begin
		res_load = 1'b0;
		res_d    = res_q;
		if (state_q == S_DIV) begin
			res_load         = 1'b1;
			res_d.kind       = ctd_pkg::KIND_CAL;
			res_d.touched    = 1'b0;
			res_d.peak       = 16'd0;
			res_d.baseline   = quot;
			res_d.fault      = (quot > fault_limit_q);
		end else if (state_q == S_EVAL && !grp_open) begin
			res_load         = 1'b1;
			res_d.kind       = ctd_pkg::KIND_SCAN;
			res_d.touched    = touched;
			res_d.peak       = group_peak_q;
			res_d.baseline   = baseline_q;
			res_d.fault      = (baseline_q > fault_limit_q);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_margin_q     <= ctd_pkg::TOUCH_MARGIN_RST;
			upper_multiple_q   <= ctd_pkg::UPPER_MULTIPLE_RST;
			holdoff_count_q    <= ctd_pkg::HOLDOFF_COUNT_RST;
			group_single_q     <= ctd_pkg::GROUP_SINGLE_RST;
			group_continuous_q <= ctd_pkg::GROUP_CONTINUOUS_RST;
			fault_limit_q      <= ctd_pkg::FAULT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ctd_pkg::REG_TOUCH_MARGIN:     touch_margin_q     <= cfg_data;
				ctd_pkg::REG_UPPER_MULTIPLE:   upper_multiple_q   <= cfg_data[3:0];
				ctd_pkg::REG_HOLDOFF_COUNT:    holdoff_count_q    <= cfg_data[3:0];
				ctd_pkg::REG_GROUP_SINGLE:     group_single_q     <= cfg_data[3:0];
				ctd_pkg::REG_GROUP_CONTINUOUS: group_continuous_q <= cfg_data[3:0];
				ctd_pkg::REG_FAULT_LIMIT:      fault_limit_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Working registers of the sequencer (payload, no reset)
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					smp_q  <= in_item.sample;
					cont_q <= in_item.continuous;
					i_q    <= '0;
					sum_q  <= '0;
				end
			end
			S_CAL_LATCH: begin
				pivot_q <= rd_data_q;
				j_q     <= '0;
				rank_q  <= '0;
			end
			S_CAL_RANK: begin
				if (j_q != CNT_W'(CAL_SAMPLES)) begin
					j_q        <= j_q + CNT_W'(1);
					cmp_idx_s1 <= j_q[IDX_W-1:0];
				end
				if (cmp_vld_s1 && cmp_less) begin
					rank_q <= rank_q + CNT_W'(1);
				end
			end
			S_CAL_ACC: begin
				sum_q <= sum_nxt;
				i_q   <= i_q + IDX_W'(1);
			end
			S_CAL_PIVOT, S_DIV, S_SCAN, S_EVAL, S_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cal_cnt_q     <= '0;
			baseline_q    <= '0;
			lockout_q     <= '0;
			group_count_q <= '0;
			group_peak_q  <= '0;
			group_mode_q  <= 1'b0;
			cmp_vld_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_item.cmd == ctd_pkg::CMD_SCAN) begin
							state_q <= S_SCAN;
						end else if (cal_cnt_q == IDX_W'(CAL_SAMPLES - 1)) begin
							cal_cnt_q <= '0;
							state_q   <= S_CAL_PIVOT;
						end else begin
							cal_cnt_q <= cal_cnt_q + IDX_W'(1);
						end
					end
				end
				S_CAL_PIVOT: begin
					state_q <= S_CAL_LATCH;
				end
				S_CAL_LATCH: begin
					cmp_vld_s1 <= 1'b0;
					state_q    <= S_CAL_RANK;
				end
				S_CAL_RANK: begin
					cmp_vld_s1 <= (j_q != CNT_W'(CAL_SAMPLES));
					if (j_q == CNT_W'(CAL_SAMPLES) && !cmp_vld_s1) begin
						state_q <= S_CAL_ACC;
					end
				end
				S_CAL_ACC: begin
					if (i_q == IDX_W'(CAL_SAMPLES - 1)) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_CAL_PIVOT;
					end
				end
				S_DIV: begin
					baseline_q <= quot;
					state_q    <= S_PUSH;
				end
				S_SCAN: begin
					group_mode_q  <= mode_new;
					group_peak_q  <= peak_new;
					group_count_q <= group_count_q + 4'd1;
					if (group_count_q == 4'd0 && cont_q) begin
						lockout_q <= 4'd0;
					end
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (grp_open) begin
						state_q <= S_IDLE;
					end else begin
						group_count_q <= 4'd0;
						lockout_q     <= lock_nxt;
						state_q       <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_PUSH && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH && out_free) begin
			out_item <= res_q;
		end
	end

endmodule

// ----- rtl/ctd_checker.sv -----
`timescale 1ns / 1ps

module ctd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input ctd_pkg::in_item_t              in_item,
	input logic                           out_valid,
	input logic                           out_ready,
	input ctd_pkg::out_item_t             out_item,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [ctd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat changed while stalled");

	// Calibration results carry no touch and no peak
	a_cal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == ctd_pkg::KIND_CAL |->
			!out_item.touched && out_item.peak == 16'd0)
		else $error("calibration result with touch or peak");

	// A scan beat keeps the block busy for the next cycle
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.cmd == ctd_pkg::CMD_SCAN |=> !in_ready)
		else $error("ready straight after a scan beat");

	// A reported touch always lies above the baseline
	a_touch_above: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.touched |->
			out_item.kind == ctd_pkg::KIND_SCAN && out_item.peak > out_item.baseline)
		else $error("touch reported at or below baseline");

	// Configuration port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind capacitive_touch_detector_top ctd_checker u_ctd_checker (.*);

// ----- tb/sv/tb_capacitive_touch_detector_top.sv -----
`timescale 1ns / 1ps

module tb_capacitive_touch_detector_top;

	localparam int CYCLE_LIMIT   = 1_500_000;
	// covers the longest calibration pass with room to spare
	localparam int SETTLE_CYCLES = 200;
	localparam int REPORT_LIMIT  = 10;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_style_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	ctd_pkg::in_item_t              in_item   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	ctd_pkg::out_item_t             out_item;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ctd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	capacitive_touch_detector_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Register shadow copy
	logic [15:0] touch_margin   = ctd_pkg::TOUCH_MARGIN_RST;
	logic [3:0]  upper_multiple = ctd_pkg::UPPER_MULTIPLE_RST;
	logic [3:0]  holdoff_count  = ctd_pkg::HOLDOFF_COUNT_RST;
	logic [3:0]  size_single    = ctd_pkg::GROUP_SINGLE_RST;
	logic [3:0]  size_cont      = ctd_pkg::GROUP_CONTINUOUS_RST;
	logic [15:0] fault_limit    = ctd_pkg::FAULT_LIMIT_RST;

	// Detector state as the key qualifier sees it
	logic [15:0] cal_buf [ctd_pkg::CAL_SAMPLES_DEF];
	logic [$clog2(ctd_pkg::CAL_SAMPLES_DEF+1)-1:0] cal_fill = '0;
	logic [15:0] base_level   = '0;
	logic [3:0]  lockout_left = '0;
	logic [3:0]  grp_count    = '0;
	logic [15:0] grp_peak     = '0;
	logic        grp_cont     = 1'b0;

	ctd_pkg::out_item_t awaited_reports [$];

	int unsigned mismatches   = 0;
	int unsigned items_sent   = 0;
	int unsigned cfg_writes   = 0;
	int unsigned cal_reports  = 0;
	int unsigned cal_faults   = 0;
	int unsigned scan_reports = 0;
	int unsigned touches_seen = 0;
	int unsigned cycle_count  = 0;

	// Sender pacing
	int unsigned burst_left  = 0;
	int unsigned pending_gap = 0;
	bit          valid_held  = 1'b0;

	// Receiver pacing
	rx_style_t   rx_style    = RX_OPEN;
	int unsigned rx_run_left = 0;

	// Sorted, trimmed mean of the calibration buffer
	function automatic logic [15:0] trimmed_mean();
		logic [15:0] s [ctd_pkg::CAL_SAMPLES_DEF];
		logic [15:0] t;
		logic [31:0] sum;
		logic [31:0] q;
		int i, j, trim, kept;
		for (i = 0; i < ctd_pkg::CAL_SAMPLES_DEF; i++)
			s[i] = cal_buf[i];
		for (i = 0; i < ctd_pkg::CAL_SAMPLES_DEF; i++)
			for (j = i + 1; j < ctd_pkg::CAL_SAMPLES_DEF; j++)
				if (s[i] > s[j]) begin
					t = s[i];
					s[i] = s[j];
					s[j] = t;
				end
		trim = ctd_pkg::TRIM_EACH_SIDE_DEF;
		if (2 * trim >= ctd_pkg::CAL_SAMPLES_DEF)
			trim = (ctd_pkg::CAL_SAMPLES_DEF - 1) / 2;
		kept = ctd_pkg::CAL_SAMPLES_DEF - 2 * trim;
		sum = '0;
		for (i = trim; i < trim + kept; i++)
			sum = sum + 32'(s[i]);
		q = sum / 32'(kept);
		return q[15:0];
	endfunction

	// Works out the report (if any) caused by one accepted sample
	task automatic qualify_sample(input ctd_pkg::in_item_t it);
		ctd_pkg::out_item_t rep;
		logic [3:0]  grp_size;
		logic [31:0] floor32, ceil32, peak32;
		rep = '0;
		if (it.cmd == ctd_pkg::CMD_CAL) begin
			cal_buf[cal_fill] = it.sample;
			cal_fill = cal_fill + 1'b1;
			if (cal_fill == ctd_pkg::CAL_SAMPLES_DEF) begin
				cal_fill     = '0;
				base_level   = trimmed_mean();
				rep.kind     = ctd_pkg::KIND_CAL;
				rep.baseline = base_level;
				rep.fault    = base_level > fault_limit;
				awaited_reports.push_back(rep);
			end
		end else begin
			// mode is latched on the first sample of a group
			if (grp_count == 4'd0) begin
				grp_cont = it.continuous;
				grp_peak = '0;
				if (grp_cont)
					lockout_left = '0;
			end
			if (it.sample > grp_peak)
				grp_peak = it.sample;
			grp_count = grp_count + 4'd1;
			grp_size  = grp_cont ? size_cont : size_single;
			if (grp_size == 4'd0)
				grp_size = 4'd1;
			if (grp_count == 4'd0 || grp_count >= grp_size) begin
				grp_count = '0;
				peak32  = 32'(grp_peak);
				floor32 = 32'(base_level) + 32'(touch_margin);
				ceil32  = 32'(upper_multiple) * 32'(base_level);
				rep.kind = ctd_pkg::KIND_SCAN;
				if (peak32 > floor32 && peak32 < ceil32) begin
					rep.touched  = (lockout_left == 4'd0);
					lockout_left = holdoff_count;
				end
				if (lockout_left != 4'd0)
					lockout_left = lockout_left - 4'd1;
				rep.peak     = grp_peak;
				rep.baseline = base_level;
				rep.fault    = base_level > fault_limit;
				awaited_reports.push_back(rep);
			end
		end
	endtask

	function automatic ctd_pkg::in_item_t make_item(input logic cmd, input logic [15:0] s,
			input logic cont);
		ctd_pkg::in_item_t it;
		it.cmd        = cmd;
		it.sample     = s;
		it.continuous = cont;
		return it;
	endfunction

	// One beat on the sample channel, with burst/gap pacing
	task automatic send_item(input ctd_pkg::in_item_t it);
		if (!valid_held) begin
			repeat (pending_gap) @(posedge clk);
			in_valid <= 1'b1;
		end
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		qualify_sample(it);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
			pending_gap = 0;
		end else begin
			burst_left  = $urandom_range(0, 24);
			pending_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
		end
		if (pending_gap > 0) begin
			in_valid   <= 1'b0;
			valid_held = 1'b0;
		end else begin
			valid_held = 1'b1;
		end
	endtask

	// Called in the step of the last acceptance, before time moves on
	task automatic release_input();
		if (valid_held) begin
			in_valid   <= 1'b0;
			valid_held = 1'b0;
		end
	endtask

	task automatic drain_reports();
		release_input();
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_register(input logic [ctd_pkg::CFG_IDX_W-1:0] idx,
			input logic [ctd_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			ctd_pkg::REG_TOUCH_MARGIN:     touch_margin   = data;
			ctd_pkg::REG_UPPER_MULTIPLE:   upper_multiple = data[3:0];
			ctd_pkg::REG_HOLDOFF_COUNT:    holdoff_count  = data[3:0];
			ctd_pkg::REG_GROUP_SINGLE:     size_single    = data[3:0];
			ctd_pkg::REG_GROUP_CONTINUOUS: size_cont      = data[3:0];
			ctd_pkg::REG_FAULT_LIMIT:      fault_limit    = data;
			default: ;
		endcase
	endtask

	// Writes all six registers back to back; only called while idle
	task automatic write_config(input logic [15:0] margin, input logic [3:0] mult,
			input logic [3:0] holdoff, input logic [3:0] gsingle, input logic [3:0] gcont,
			input logic [15:0] flimit);
		logic [ctd_pkg::CFG_IDX_W-1:0]  idx  [6];
		logic [ctd_pkg::CFG_DATA_W-1:0] vals [6];
		logic [11:0]                    junk;
		int i;
		idx[0] = ctd_pkg::REG_TOUCH_MARGIN;
		idx[1] = ctd_pkg::REG_UPPER_MULTIPLE;
		idx[2] = ctd_pkg::REG_HOLDOFF_COUNT;
		idx[3] = ctd_pkg::REG_GROUP_SINGLE;
		idx[4] = ctd_pkg::REG_GROUP_CONTINUOUS;
		idx[5] = ctd_pkg::REG_FAULT_LIMIT;
		// upper bits of three of the narrow registers carry noise, they must be ignored
		junk = 12'($urandom);
		vals[0] = margin;
		vals[1] = {junk, mult};
		vals[2] = {~junk, holdoff};
		vals[3] = {junk ^ 12'h5a5, gsingle};
		vals[4] = {12'h000, gcont};
		vals[5] = flimit;
		cfg_valid <= 1'b1;
		for (i = 0; i < 6; i++) begin
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			apply_register(idx[i], vals[i]);
			cfg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	// Receiver: runs of one stall style at a time
	always @(posedge clk) begin
		if (rx_run_left == 0) begin
			rx_style    = rx_style_t'($urandom_range(0, 3));
			rx_run_left = $urandom_range(16, 128);
		end else begin
			rx_run_left--;
		end
		case (rx_style)
			RX_OPEN:  out_ready <= 1'b1;
			RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
			default:  out_ready <= ~out_ready;
		endcase
	end

	// Result checker
	always @(posedge clk) begin : check_reports
		ctd_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected beat: kind %0d touched %0d peak %0d base %0d flt %0d",
						out_item.kind, out_item.touched, out_item.peak,
						out_item.baseline, out_item.fault);
			end else begin
				want = awaited_reports.pop_front();
				if (out_item.kind !== want.kind || out_item.touched !== want.touched ||
						out_item.peak !== want.peak || out_item.baseline !== want.baseline ||
						out_item.fault !== want.fault) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("mismatch at %0t: exp kind %0d touched %0d peak %0d base %0d flt %0d",
							$realtime, want.kind, want.touched, want.peak,
							want.baseline, want.fault);
						$display("  got kind %0d touched %0d peak %0d base %0d flt %0d",
							out_item.kind, out_item.touched, out_item.peak,
							out_item.baseline, out_item.fault);
					end
				end
				if (want.kind == ctd_pkg::KIND_CAL) begin
					cal_reports++;
					if (want.fault)
						cal_faults++;
				end else begin
					scan_reports++;
					if (want.touched)
						touches_seen++;
				end
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Scan with no calibration yet: baseline is zero, so never a touch
	task automatic test_scan_before_calibration();
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'h0000, 1'b0));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'hffff, 1'b1));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'h8000, 1'b0));
	endtask

	// Calibration with extremes in the trimmed ends and a scan sample in the middle
	task automatic test_calibration_interleaved();
		send_item(make_item(ctd_pkg::CMD_CAL, 16'hffff, 1'b0));
		send_item(make_item(ctd_pkg::CMD_CAL, 16'h0000, 1'b1));
		send_item(make_item(ctd_pkg::CMD_CAL, 16'd1200, 1'b0));
		send_item(make_item(ctd_pkg::CMD_CAL, 16'd1100, 1'b0));
		send_item(make_item(ctd_pkg::CMD_CAL, 16'd1000, 1'b0));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1500, 1'b0));
		send_item(make_item(ctd_pkg::CMD_CAL, 16'd900, 1'b0));
		send_item(make_item(ctd_pkg::CMD_CAL, 16'd800, 1'b0));
		send_item(make_item(ctd_pkg::CMD_CAL, 16'd700, 1'b0));
		send_item(make_item(ctd_pkg::CMD_CAL, 16'hfffe, 1'b0));
		send_item(make_item(ctd_pkg::CMD_CAL, 16'h0001, 1'b0));
	endtask

	// Touch report, lockout cleared by a continuous group, then suppressed repeat
	task automatic test_touch_and_holdoff();
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1200, 1'b1));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd0, 1'b1));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd900, 1'b1));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd2000, 1'b0));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1000, 1'b0));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd950, 1'b0));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1500, 1'b0));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd980, 1'b0));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1100, 1'b0));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1050, 1'b1));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1000, 1'b0));
		drain_reports();
	endtask

	// Group size lowered under a part-filled group, zero sizes, fault limit edge
	task automatic test_group_size_and_fault_limit();
		write_config(16'd100, 4'd10, 4'd3, 4'd8, 4'd6, 16'd949);
		repeat (4) send_item(make_item(ctd_pkg::CMD_SCAN, 16'($urandom_range(0, 3000)), 1'b0));
		drain_reports();
		write_config(16'd100, 4'd10, 4'd3, 4'd2, 4'd6, 16'd950);
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1400, 1'b1));
		drain_reports();
		write_config(16'd100, 4'd10, 4'd0, 4'd0, 4'd0, 16'd949);
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1300, 1'b0));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1300, 1'b1));
		send_item(make_item(ctd_pkg::CMD_SCAN, 16'd1300, 1'b0));
		drain_reports();
	endtask

	// Random phases, each with its own register set and charge-time level
	task automatic test_random_phases();
		int unsigned p, n, level, v;
		logic [15:0] margin, flimit;
		logic [3:0]  mult, holdoff, gsingle, gcont;
		ctd_pkg::in_item_t it;
		for (p = 0; p < 12; p++) begin
			level = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(20, 4000);
			if (p == 0) begin
				margin = '0; mult = '0; holdoff = '0; gsingle = '0; gcont = '0; flimit = '0;
			end else if (p == 1) begin
				margin = '1; mult = '1; holdoff = '1; gsingle = '1; gcont = '1; flimit = '1;
			end else begin
				margin  = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 400));
				mult    = 4'($urandom_range(0, 15));
				holdoff = 4'($urandom_range(0, 15));
				gsingle = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
					: $urandom_range(1, 6));
				gcont   = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
					: $urandom_range(1, 8));
				v       = level + $urandom_range(0, level / 4 + 10);
				flimit  = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
					: ((v > 65535) ? 16'hffff : 16'(v));
			end
			write_config(margin, mult, holdoff, gsingle, gcont, flimit);
			for (n = 0; n < 125; n++) begin
				it.cmd        = ($urandom_range(0, 99) < 25) ? ctd_pkg::CMD_CAL
					: ctd_pkg::CMD_SCAN;
				it.continuous = 1'($urandom_range(0, 1));
				// mostly samples around the phase level, some raw noise
				if ($urandom_range(0, 9) == 0)
					v = $urandom_range(0, 65535);
				else if (it.cmd == ctd_pkg::CMD_CAL)
					v = level + $urandom_range(0, level / 8 + 2);
				else
					v = level + $urandom_range(0, 2 * level + 200);
				it.sample = (v > 65535) ? 16'hffff : 16'(v);
				send_item(it);
			end
			drain_reports();
		end
	endtask

	initial begin : run
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_scan_before_calibration();
		test_calibration_interleaved();
		test_touch_and_holdoff();
		test_group_size_and_fault_limit();
		test_random_phases();
		drain_reports();
		$display("covered %0d samples, %0d register writes, %0d calibrations (%0d over limit)",
			items_sent, cfg_writes, cal_reports, cal_faults);
		$display("%0d scan groups with %0d touches reported, %0d mismatches",
			scan_reports, touches_seen, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
